FILE: rtl/homogeneous_point_transform_macros.svh
// assertion macros shared by the rtl
`ifndef HOMOGENEOUS_POINT_TRANSFORM_MACROS_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_MACROS_SVH
`ifndef SYNTH
`define HPT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hpt assertion failed");
`define HPT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("hpt forbidden condition");
`else
`define HPT_ASSERT(lbl, clk, rst_n, prop)
`define HPT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

FILE: rtl/hpt_pkg.sv
package hpt_pkg;
    localparam int PW = 32;
    localparam int EW = 16;
    localparam int MW = PW + EW;
    localparam int SW = 50;
    localparam int QW = 32;
    localparam int LANES = 3;
    localparam int ROWS = 4;

    typedef logic [63:0] t_row;

    typedef enum logic [1:0] {
        REG_ROW0 = 2'd0,
        REG_ROW1 = 2'd1,
        REG_ROW2 = 2'd2,
        REG_ROW3 = 2'd3
    } t_reg_idx;

    localparam t_row ROW0_RESET = 64'h0000_0000_0000_1000;
    localparam t_row ROW1_RESET = 64'h0000_0000_1000_0000;
    localparam t_row ROW2_RESET = 64'h0000_1000_0000_0000;
    localparam t_row ROW3_RESET = 64'h1000_0000_0000_0000;

    localparam logic [QW-1:0] POS_LIMIT = 32'h7fff_ffff;
    localparam logic [QW-1:0] NEG_LIMIT = 32'h8000_0000;

    typedef struct packed {
        logic [LANES-1:0][SW-1:0] num;
        logic [SW-1:0]            den;
        logic [LANES-1:0]         neg;
        logic                     w_zero;
    } t_div_req;

    typedef struct packed {
        logic [LANES-1:0][SW-1:0] rem;
        logic [LANES-1:0][QW-1:0] low;
        logic [LANES-1:0][QW-1:0] quo;
        logic [LANES-1:0]         ovf;
        logic [LANES-1:0]         neg;
        logic [SW-1:0]            den;
        logic                     w_zero;
    } t_div_st;

    typedef struct packed {
        logic [LANES-1:0][QW-1:0] coord;
        logic                     w_zero;
        logic                     clipped;
    } t_res;
endpackage

FILE: rtl/hpt_if.sv
interface hpt_pt_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    modport source(output valid, px, py, pz, input ready);
    modport sink(input valid, px, py, pz, output ready);
endinterface

interface hpt_res_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
    logic              w_zero;
    logic              clipped;
    modport source(output valid, tx, ty, tz, w_zero, clipped, input ready);
    modport sink(input valid, tx, ty, tz, w_zero, clipped, output ready);
endinterface

FILE: rtl/homogeneous_point_transform.sv
// channel   dir  payload                               handshake
// i_pt      in   px, py, pz (q16.16)                   valid/ready
// o_res     out  tx, ty, tz (q16.16), w_zero, clipped  valid/ready
// apb       in   row0..row3 at 0x00/0x08/0x10/0x18     psel/penable, pready high
//
// one beat per cycle unless stalled; 3 front stages, queue, 33 divider stages, 1 out
// the divider takes one quotient bit per stage, three lanes in parallel
// synchronous active-low reset empties the pipeline and loads the identity matrix
// an output stall backs up the divider, then the queue, then the multiply front
module homogeneous_point_transform #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hpt_pt_if.sink      i_pt,
    hpt_res_if.source   o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    hpt_pkg::t_row     r_rows [hpt_pkg::ROWS];
    hpt_pkg::t_div_req f_req, q_req;
    hpt_pkg::t_res     res;
    hpt_pkg::t_reg_idx idx;
    logic              f_valid, q_full, q_valid, b_ready;

    assign pready = 1'b1;
    assign idx    = hpt_pkg::t_reg_idx'(paddr[4:3]);
    assign prdata = r_rows[paddr[4:3]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows[0] <= hpt_pkg::ROW0_RESET;
            r_rows[1] <= hpt_pkg::ROW1_RESET;
            r_rows[2] <= hpt_pkg::ROW2_RESET;
            r_rows[3] <= hpt_pkg::ROW3_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (idx)
                hpt_pkg::REG_ROW0: r_rows[0] <= pwdata;
                hpt_pkg::REG_ROW1: r_rows[1] <= pwdata;
                hpt_pkg::REG_ROW2: r_rows[2] <= pwdata;
                hpt_pkg::REG_ROW3: r_rows[3] <= pwdata;
                default: ;
            endcase
        end
    end

    hpt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rows  (r_rows),
        .i_valid (i_pt.valid),
        .o_ready (i_pt.ready),
        .i_px    (i_pt.px),
        .i_py    (i_pt.py),
        .i_pz    (i_pt.pz),
        .o_valid (f_valid),
        .i_ready (!q_full),
        .o_req   (f_req)
    );

    hpt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  (f_req),
        .o_full  (q_full),
        .i_pop   (b_ready),
        .o_valid (q_valid),
        .o_data  (q_req)
    );

    hpt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (b_ready),
        .i_req   (q_req),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_res   (res)
    );

    assign o_res.tx      = $signed(res.coord[0]);
    assign o_res.ty      = $signed(res.coord[1]);
    assign o_res.tz      = $signed(res.coord[2]);
    assign o_res.w_zero  = res.w_zero;
    assign o_res.clipped = res.clipped;
endmodule

FILE: rtl/hpt_front.sv
module hpt_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  hpt_pkg::t_row        i_rows [hpt_pkg::ROWS],
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [31:0]   i_px,
    input  logic signed [31:0]   i_py,
    input  logic signed [31:0]   i_pz,
    output logic                 o_valid,
    input  logic                 i_ready,
    output hpt_pkg::t_div_req    o_req
);
    logic signed [hpt_pkg::MW-1:0] r_prod [hpt_pkg::ROWS][hpt_pkg::LANES];
    logic signed [hpt_pkg::EW-1:0] r_m3 [hpt_pkg::ROWS];
    logic signed [hpt_pkg::SW-1:0] r_sum [hpt_pkg::ROWS];
    hpt_pkg::t_div_req             r_req, n_req;
    logic                          r_va, r_vb, r_vc;
    logic                          en;

    assign en      = !r_vc || i_ready;
    assign o_ready = en;
    assign o_valid = r_vc;
    assign o_req   = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    // one multiplier per lane and row
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < hpt_pkg::ROWS; r++) begin
                r_prod[r][0] <= $signed(i_rows[r][15:0])  * i_px;
                r_prod[r][1] <= $signed(i_rows[r][31:16]) * i_py;
                r_prod[r][2] <= $signed(i_rows[r][47:32]) * i_pz;
                r_m3[r]      <= $signed(i_rows[r][63:48]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < hpt_pkg::ROWS; r++) begin
                r_sum[r] <= 50'(r_prod[r][0]) + 50'(r_prod[r][1]) + 50'(r_prod[r][2])
                    + $signed({{18{r_m3[r][15]}}, r_m3[r], 16'b0});
            end
        end
    end

    // magnitudes and quotient signs for the divider
    always_comb begin
        n_req.den    = r_sum[3][49] ? 50'(-r_sum[3]) : 50'(r_sum[3]);
        n_req.w_zero = (r_sum[3] == '0);
        for (int k = 0; k < hpt_pkg::LANES; k++) begin
            n_req.num[k] = r_sum[k][49] ? 50'(-r_sum[k]) : 50'(r_sum[k]);
            n_req.neg[k] = r_sum[k][49] ^ r_sum[3][49];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_req <= n_req;
        end
    end
endmodule

FILE: rtl/hpt_queue.sv
`include "homogeneous_point_transform_macros.svh"
module hpt_queue #(
    parameter int DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  hpt_pkg::t_div_req i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output hpt_pkg::t_div_req o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hpt_pkg::t_div_req r_mem [DEPTH];
    logic [AW-1:0]     r_wr, r_rd;
    logic [CW-1:0]     r_cnt;
    logic              push, pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign push    = i_push && !o_full;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CW'(push) - CW'(pop);
        end
    end

    `HPT_NEVER(a_q_over, i_clk, i_rst_n, r_cnt > CW'(DEPTH))
    `HPT_ASSERT(a_q_pop_moves, i_clk, i_rst_n, pop && !push |=> r_cnt == $past(r_cnt) - 1'b1)
    `HPT_ASSERT(a_q_push_moves, i_clk, i_rst_n, push && !pop |=> r_cnt == $past(r_cnt) + 1'b1)
endmodule

FILE: rtl/hpt_back.sv
`include "homogeneous_point_transform_macros.svh"
module hpt_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  hpt_pkg::t_div_req i_req,
    output logic              o_valid,
    input  logic              i_ready,
    output hpt_pkg::t_res     o_res
);
    localparam int NS = hpt_pkg::QW + 1;

    hpt_pkg::t_div_st r_st [NS];
    logic [NS-1:0]    r_v;
    hpt_pkg::t_div_st n_st [NS];
    hpt_pkg::t_res    r_res, n_res;
    logic             r_vo;
    logic             en;

    assign en      = !r_vo || i_ready;
    assign o_ready = en;
    assign o_valid = r_vo;
    assign o_res   = r_res;

    // seed: high dividend bits as remainder, overflow when quotient needs 2^32
    always_comb begin
        n_st[0].den    = i_req.den;
        n_st[0].neg    = i_req.neg;
        n_st[0].w_zero = i_req.w_zero;
        for (int k = 0; k < hpt_pkg::LANES; k++) begin
            n_st[0].rem[k] = {16'b0, i_req.num[k][49:16]};
            n_st[0].low[k] = {i_req.num[k][15:0], 16'b0};
            n_st[0].quo[k] = '0;
            n_st[0].ovf[k] = ({16'b0, i_req.num[k][49:16]} >= i_req.den);
        end
    end

    for (genvar s = 1; s < NS; s++) begin : g_step
        always_comb begin
            logic [hpt_pkg::SW:0] trial;
            n_st[s] = r_st[s-1];
            for (int k = 0; k < hpt_pkg::LANES; k++) begin
                trial = {r_st[s-1].rem[k], r_st[s-1].low[k][31]};
                n_st[s].low[k] = {r_st[s-1].low[k][30:0], 1'b0};
                if (trial >= {1'b0, r_st[s-1].den}) begin
                    n_st[s].rem[k] = 50'(trial - {1'b0, r_st[s-1].den});
                    n_st[s].quo[k] = {r_st[s-1].quo[k][30:0], 1'b1};
                end else begin
                    n_st[s].rem[k] = trial[hpt_pkg::SW-1:0];
                    n_st[s].quo[k] = {r_st[s-1].quo[k][30:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int s = 0; s < NS; s++) begin
                r_st[s] <= n_st[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_vo <= 1'b0;
        end else if (en) begin
            r_v  <= {r_v[NS-2:0], i_valid};
            r_vo <= r_v[NS-1];
        end
    end

    // sign, saturation and zero w
    always_comb begin
        logic [hpt_pkg::QW-1:0] limit;
        logic                   sat;
        n_res.clipped = 1'b0;
        n_res.w_zero  = r_st[NS-1].w_zero;
        for (int k = 0; k < hpt_pkg::LANES; k++) begin
            limit = r_st[NS-1].neg[k] ? hpt_pkg::NEG_LIMIT : hpt_pkg::POS_LIMIT;
            sat   = r_st[NS-1].ovf[k] || (r_st[NS-1].quo[k] > limit);
            if (r_st[NS-1].w_zero) begin
                n_res.coord[k] = '0;
            end else if (sat) begin
                n_res.coord[k] = limit;
                n_res.clipped  = 1'b1;
            end else if (r_st[NS-1].neg[k]) begin
                n_res.coord[k] = 32'(-r_st[NS-1].quo[k]);
            end else begin
                n_res.coord[k] = r_st[NS-1].quo[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res <= n_res;
        end
    end

    `HPT_ASSERT(a_wz_zero, i_clk, i_rst_n, r_vo && r_res.w_zero |-> r_res.coord == '0 && !r_res.clipped)
    `HPT_ASSERT(a_pipe_shift, i_clk, i_rst_n, en && r_v[0] |=> r_v[1])
    `HPT_ASSERT(a_stall_hold, i_clk, i_rst_n, !en |=> $stable(r_v) && $stable(r_res))
endmodule

FILE: bench/homogeneous_point_transform_test.sv
`timescale 1ns / 100ps

module homogeneous_point_transform_test;
    typedef struct {
        logic [31:0] tx;
        logic [31:0] ty;
        logic [31:0] tz;
        logic        w_zero;
        logic        clipped;
    } t_point_out;

    typedef struct {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        bit          typed;
        t_point_out  want;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    hpt_pt_if  pt_if ();
    hpt_res_if res_if ();

    homogeneous_point_transform uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    hpt_pkg::t_row matrix [hpt_pkg::ROWS];
    t_point_out    pending_points [$];
    t_stim_row     directed_rows [$];
    int            errors = 0;
    int            src_idle_pct = 15;
    int            sink_idle_pct = 15;
    int            sink_hold = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("** homogeneous_point_transform: FAILED **");
        $finish;
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        errors++;
    endtask

    // quotient of two row sums, q16.16, truncated toward zero and saturated
    function automatic logic [31:0] div_q16(longint signed num, longint signed den,
                                            inout bit sat);
        bit           neg;
        logic [127:0] n;
        logic [127:0] d;
        logic [127:0] q;
        logic [127:0] limit;
        neg = (num < 0) != (den < 0);
        n = 128'((num < 0) ? -num : num);
        d = 128'((den < 0) ? -den : den);
        q = (n << 16) / d;
        limit = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        if (q > limit) begin
            sat = 1'b1;
            q = limit;
        end
        return neg ? -q[31:0] : q[31:0];
    endfunction

    function automatic t_point_out transform_point(logic [31:0] x, logic [31:0] y,
                                                   logic [31:0] z);
        longint signed coord [4];
        longint signed sums [4];
        bit            sat;
        t_point_out    r;
        coord[0] = longint'($signed(x));
        coord[1] = longint'($signed(y));
        coord[2] = longint'($signed(z));
        coord[3] = 65536;
        sat = 1'b0;
        for (int i = 0; i < hpt_pkg::ROWS; i++) begin
            sums[i] = 0;
            for (int j = 0; j < 4; j++)
                sums[i] += longint'($signed(matrix[i][16*j +: 16])) * coord[j];
        end
        if (sums[3] == 0) begin
            r = '{32'd0, 32'd0, 32'd0, 1'b1, 1'b0};
        end else begin
            r.tx = div_q16(sums[0], sums[3], sat);
            r.ty = div_q16(sums[1], sums[3], sat);
            r.tz = div_q16(sums[2], sums[3], sat);
            r.w_zero = 1'b0;
            r.clipped = sat;
        end
        return r;
    endfunction

    task automatic write_row(hpt_pkg::t_reg_idx idx, hpt_pkg::t_row value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        matrix[idx] = value;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // let the divider pipeline drain and settle before touching the matrix
    task automatic drain();
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              bit typed, t_point_out want);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            pt_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        pt_if.valid <= 1'b1;
        pt_if.px <= x;
        pt_if.py <= y;
        pt_if.pz <= z;
        do @(posedge i_clk); while (!pt_if.ready);
        pending_points.push_back(typed ? want : transform_point(x, y, z));
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        pt_if.valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(2))
            0: return $urandom;
            1: return $urandom_range(32'h000f_ffff) ^ {32{1'($urandom_range(1))}};
            default: return $urandom_range(32'h0007_ffff) - 32'h0004_0000;
        endcase
    endfunction

    function automatic logic [15:0] rand_entry(bit diag);
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return diag ? 16'(16'h1000 + $urandom_range(16'h0800) - 16'h0400) : 16'h0000;
            default: return 16'($urandom_range(16'h0fff) - 16'h0800);
        endcase
    endfunction

    task automatic write_random_matrix();
        hpt_pkg::t_row r;
        for (int i = 0; i < hpt_pkg::ROWS; i++) begin
            for (int j = 0; j < 4; j++)
                r[16*j +: 16] = rand_entry(i == j);
            write_row(hpt_pkg::t_reg_idx'(i), r);
        end
    endtask

    task automatic add_row(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit typed,
                           t_point_out want);
        directed_rows.push_back('{x, y, z, typed, want});
    endtask

    task automatic run_directed();
        foreach (directed_rows[k])
            send_point(directed_rows[k].px, directed_rows[k].py, directed_rows[k].pz,
                       directed_rows[k].typed, directed_rows[k].want);
        end_burst();
        directed_rows.delete();
        drain();
    endtask

    // result side: random stalls plus a long hold-off on request
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold > 0) begin
                sink_hold--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_point_out want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_points.size() == 0) begin
                report_mismatch("unexpected beat", res_if.tx, 32'h0);
            end else begin
                want = pending_points.pop_front();
                if (res_if.tx !== want.tx) report_mismatch("tx", res_if.tx, want.tx);
                if (res_if.ty !== want.ty) report_mismatch("ty", res_if.ty, want.ty);
                if (res_if.tz !== want.tz) report_mismatch("tz", res_if.tz, want.tz);
                if (res_if.w_zero !== want.w_zero)
                    report_mismatch("w_zero", 32'(res_if.w_zero), 32'(want.w_zero));
                if (res_if.clipped !== want.clipped)
                    report_mismatch("clipped", 32'(res_if.clipped), 32'(want.clipped));
            end
        end
    end

    initial begin
        t_point_out    none;
        hpt_pkg::t_row r;
        none = '{32'd0, 32'd0, 32'd0, 1'b0, 1'b0};
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pt_if.valid = 1'b0;
        pt_if.px = '0;
        pt_if.py = '0;
        pt_if.pz = '0;
        matrix[0] = hpt_pkg::ROW0_RESET;
        matrix[1] = hpt_pkg::ROW1_RESET;
        matrix[2] = hpt_pkg::ROW2_RESET;
        matrix[3] = hpt_pkg::ROW3_RESET;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // identity after reset passes points through untouched
        add_row(32'h0, 32'h0, 32'h0, 1, '{32'h0, 32'h0, 32'h0, 1'b0, 1'b0});
        add_row(32'h0001_0000, 32'hfffe_0000, 32'h0003_8000, 1,
                '{32'h0001_0000, 32'hfffe_0000, 32'h0003_8000, 1'b0, 1'b0});
        add_row(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 1,
                '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 1'b0, 1'b0});
        add_row(32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0001, 1,
                '{32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0001, 1'b0, 1'b0});
        add_row(32'haaaa_aaaa, 32'h5555_5555, 32'h8000_0000, 1,
                '{32'haaaa_aaaa, 32'h5555_5555, 32'h8000_0000, 1'b0, 1'b0});
        run_directed();

        // zero w: coordinates forced to zero, flag raised
        write_row(hpt_pkg::REG_ROW3, 64'h0);
        add_row(32'h1234_5678, 32'h8000_0000, 32'h7fff_ffff, 1,
                '{32'h0, 32'h0, 32'h0, 1'b1, 1'b0});
        add_row(32'hffff_ffff, 32'h0, 32'h0000_0001, 1, '{32'h0, 32'h0, 32'h0, 1'b1, 1'b0});
        run_directed();

        // w follows the point, so it can cancel to zero or flip sign
        write_row(hpt_pkg::REG_ROW3, 64'h1000_0000_0000_1000);
        write_row(hpt_pkg::REG_ROW0, 64'h7fff_7fff_7fff_7fff);
        write_row(hpt_pkg::REG_ROW1, 64'h8000_8000_8000_8000);
        write_row(hpt_pkg::REG_ROW2, 64'hffff_ffff_ffff_ffff);
        add_row(32'hffff_0000, 32'h0, 32'h0, 0, none);
        add_row(32'hfffe_0000, 32'h1, 32'h2, 0, none);
        add_row(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, none);
        add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, none);
        add_row(32'h0000_0100, 32'hffff_ff00, 32'h0000_0010, 0, none);
        add_row(32'hfffe_ffff, 32'h0001_0000, 32'h0, 0, none);
        run_directed();

        write_row(hpt_pkg::REG_ROW0, 64'h0);
        write_row(hpt_pkg::REG_ROW3, 64'hf000_0000_0000_0000);
        add_row(32'h0100_0000, 32'hff00_0000, 32'h0000_0001, 0, none);
        add_row(32'h8000_0000, 32'h7fff_ffff, 32'h0, 0, none);
        run_directed();

        for (int phase = 0; phase < 6; phase++) begin
            write_random_matrix();
            src_idle_pct = (phase == 2) ? 0 : 15;
            sink_idle_pct = (phase == 2) ? 0 : 15;
            if (phase == 4) sink_hold = 200;
            for (int k = 0; k < 75; k++) begin
                if (phase == 3 && k == 40) begin
                    end_burst();
                    drain();
                end
                send_point(rand_coord(), rand_coord(), rand_coord(), 0, none);
            end
            end_burst();
            drain();
        end

        if (errors == 0)
            $display("** homogeneous_point_transform: PASSED **");
        else
            $display("** homogeneous_point_transform: FAILED **");
        $finish;
    end
endmodule
